// ----- design/lrc_pkg.sv -----
// Shared constants, types and CRC helper for the log record checker.
`timescale 1ns / 1ps
package lrc_pkg;

  localparam int unsigned MaxRecordWords = 16;
  localparam int unsigned PosW = $clog2(MaxRecordWords + 1);

  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] LegacyInit = 16'h5A5A;
  localparam logic [15:0] ErasedWord = 16'hFFFF;

  typedef enum logic [2:0] {
    StCrcOk    = 3'd0,
    StLegacyOk = 3'd1,
    StErased   = 3'd2,
    StBadMagic = 3'd3,
    StBadCheck = 3'd4
  } status_e;

  typedef enum logic {
    RegMagicValue = 1'b0,
    RegMagicPos   = 1'b1
  } cfg_reg_e;

  // One byte of CRC-16/CCITT, MSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CrcPoly;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- design/log_record_checker.sv -----
// Top level: streaming record checker with CRC-16 and legacy check.
// Result path: the check word waits in the input register and its verdict is
//   then registered in the result register once that register is free or being read.
// Throughput: one record word per cycle; a result stalled at the output
//   holds back only a following check word, held in the input register.
// Reset: asynchronous, active low; accumulators return to their initial
//   values, magic registers to zero, no result pending.
`timescale 1ns / 1ps
module log_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] record_word_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] computed_crc_o
);

  localparam int unsigned PosW = lrc_pkg::PosW;

  logic [15:0] magic_value_q;
  logic [3:0]  magic_pos_q;

  logic        in_valid_q;
  logic [15:0] word_q;
  logic        last_q;

  logic [15:0]     crc_q, crc_d;
  logic [15:0]     legacy_q, legacy_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            magic_ok_q, magic_ok_d;
  logic            erased_q, erased_d;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [15:0] out_crc_q;

  logic          advance;
  lrc_pkg::status_e status_d;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_value_q <= '0;
      magic_pos_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lrc_pkg::cfg_reg_e'(cfg_index_i))
        lrc_pkg::RegMagicValue: magic_value_q <= cfg_data_i;
        lrc_pkg::RegMagicPos:   magic_pos_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= record_word_i;
      last_q <= is_last_i;
    end
  end

  always_comb begin
    crc_d      = crc_q;
    legacy_d   = legacy_q;
    pos_d      = pos_q;
    magic_ok_d = magic_ok_q;
    erased_d   = erased_q;
    status_d   = lrc_pkg::StBadCheck;

    priority if (erased_q) begin
      status_d = lrc_pkg::StErased;
    end else if (!magic_ok_q) begin
      status_d = lrc_pkg::StBadMagic;
    end else if (crc_q == word_q) begin
      status_d = lrc_pkg::StCrcOk;
    end else if (legacy_q == word_q) begin
      status_d = lrc_pkg::StLegacyOk;
    end else begin
      status_d = lrc_pkg::StBadCheck;
    end

    if (last_q) begin
      crc_d      = lrc_pkg::CrcInit;
      legacy_d   = lrc_pkg::LegacyInit;
      pos_d      = '0;
      magic_ok_d = 1'b0;
      erased_d   = 1'b0;
    end else begin
      crc_d    = lrc_pkg::crc_byte(lrc_pkg::crc_byte(crc_q, word_q[7:0]), word_q[15:8]);
      legacy_d = {legacy_q[14:0], legacy_q[15]} ^ word_q;
      if (pos_q < PosW'(lrc_pkg::MaxRecordWords)) begin
        if (pos_q == PosW'(magic_pos_q)) begin
          erased_d   = (word_q == lrc_pkg::ErasedWord);
          magic_ok_d = (word_q == magic_value_q);
        end
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= lrc_pkg::CrcInit;
      legacy_q   <= lrc_pkg::LegacyInit;
      pos_q      <= '0;
      magic_ok_q <= 1'b0;
      erased_q   <= 1'b0;
    end else if (advance) begin
      crc_q      <= crc_d;
      legacy_q   <= legacy_d;
      pos_q      <= pos_d;
      magic_ok_q <= magic_ok_d;
      erased_q   <= erased_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      status_q  <= status_d;
      out_crc_q <= crc_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign computed_crc_o = out_crc_q;

endmodule

// ----- design/lrc_checker.sv -----
// Port-level assertions for the log record checker, bound to the top level.
`timescale 1ns / 1ps
module lrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [15:0] computed_crc_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(computed_crc_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'(lrc_pkg::StBadCheck))
    else $error("status code out of range");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && is_last_i, 2))
    else $error("result without a check word transaction");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind log_record_checker lrc_checker u_lrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .is_last_i      (is_last_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .computed_crc_o (computed_crc_o)
);

// ----- verif/tb_log_record_checker.sv -----
// Testbench for log_record_checker: directed and random records against a predictor.
`timescale 1ns / 1ps
module tb_log_record_checker;

  typedef struct {
    lrc_pkg::status_e status;
    logic [15:0]      crc;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i    = lrc_pkg::RegMagicValue;
  logic [15:0] cfg_data_i     = 16'h0000;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [15:0] record_word_i  = 16'h0000;
  logic        is_last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] computed_crc_o;

  log_record_checker dut (.*);

  // predictor state and register shadows
  logic [15:0] crc_run      = lrc_pkg::CrcInit;
  logic [15:0] legacy_run   = lrc_pkg::LegacyInit;
  logic [4:0]  word_idx     = '0;
  logic        magic_hit    = 1'b0;
  logic        erased_hit   = 1'b0;
  logic [15:0] magic_val_q  = 16'h0000;
  logic [3:0]  magic_pos_q  = 4'd0;

  verdict_t    expected_verdicts[$];
  logic [15:0] rec_words[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_log_record_checker: FAIL");
    $finish;
  end

  function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] d);
    logic fb;
    for (int b = 7; b >= 0; b--) begin
      fb = c[15] ^ d[b];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ lrc_pkg::CrcPoly;
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_word(logic [15:0] c, logic [15:0] w);
    return crc16_byte(crc16_byte(c, w[7:0]), w[15:8]);
  endfunction

  function automatic logic [15:0] legacy_word(logic [15:0] l, logic [15:0] w);
    return {l[14:0], l[15]} ^ w;
  endfunction

  function automatic logic [15:0] words_crc();
    logic [15:0] c;
    c = lrc_pkg::CrcInit;
    foreach (rec_words[i]) c = crc16_word(c, rec_words[i]);
    return c;
  endfunction

  function automatic logic [15:0] record_legacy();
    logic [15:0] l;
    l = lrc_pkg::LegacyInit;
    foreach (rec_words[i]) l = legacy_word(l, rec_words[i]);
    return l;
  endfunction

  function automatic void absorb_record_word(logic [15:0] w, logic last);
    verdict_t v;
    if (!last) begin
      crc_run    = crc16_word(crc_run, w);
      legacy_run = legacy_word(legacy_run, w);
      if (word_idx < lrc_pkg::MaxRecordWords) begin
        if (word_idx == {1'b0, magic_pos_q}) begin
          erased_hit = (w == lrc_pkg::ErasedWord);
          magic_hit  = (w == magic_val_q);
        end
        word_idx = word_idx + 5'd1;
      end
    end else begin
      if (erased_hit)           v.status = lrc_pkg::StErased;
      else if (!magic_hit)      v.status = lrc_pkg::StBadMagic;
      else if (crc_run == w)    v.status = lrc_pkg::StCrcOk;
      else if (legacy_run == w) v.status = lrc_pkg::StLegacyOk;
      else                      v.status = lrc_pkg::StBadCheck;
      v.crc = crc_run;
      expected_verdicts.push_back(v);
      crc_run    = lrc_pkg::CrcInit;
      legacy_run = lrc_pkg::LegacyInit;
      word_idx   = '0;
      magic_hit  = 1'b0;
      erased_hit = 1'b0;
    end
  endfunction

  // transaction monitor and scoreboard
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: status %0d crc %h", status_o, computed_crc_o);
          mismatch_count++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (status_o !== exp_v.status) begin
            $error("status: expected %0d, actual %0d", exp_v.status, status_o);
            mismatch_count++;
          end
          if (computed_crc_o !== exp_v.crc) begin
            $error("computed_crc: expected %h, actual %h", exp_v.crc, computed_crc_o);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) absorb_record_word(record_word_i, is_last_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (lrc_pkg::cfg_reg_e'(cfg_index_i))
          lrc_pkg::RegMagicValue: magic_val_q = cfg_data_i;
          lrc_pkg::RegMagicPos:   magic_pos_q = cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  // result sink: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_word(logic [15:0] w, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    record_word_i <= w;
    is_last_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_record(logic [15:0] check);
    foreach (rec_words[i]) push_word(rec_words[i], 1'b0);
    push_word(check, 1'b1);
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_config(logic [15:0] magic, logic [3:0] pos);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= lrc_pkg::RegMagicValue;
    cfg_data_i  <= magic;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= lrc_pkg::RegMagicPos;
    cfg_data_i  <= {12'h000, pos};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // let the monitor update its register shadows
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_data_word();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic build_random_record(output logic [15:0] check);
    int t, len, pos;
    pos = magic_pos_q;
    t   = $urandom_range(99);
    if (t < 65)      len = $urandom_range(lrc_pkg::MaxRecordWords, pos + 1);
    else if (t < 77) len = $urandom_range(lrc_pkg::MaxRecordWords + 5,
                                          lrc_pkg::MaxRecordWords + 1);
    else if (t < 89) len = $urandom_range(pos, 0);
    else             len = $urandom_range(3, 0);
    rec_words.delete();
    for (int i = 0; i < len; i++) rec_words.push_back(random_data_word());
    if (len > pos) begin
      t = $urandom_range(99);
      if (t < 75)      rec_words[pos] = magic_val_q;
      else if (t < 85) rec_words[pos] = lrc_pkg::ErasedWord;
    end
    t = $urandom_range(99);
    if (t < 45)      check = words_crc();
    else if (t < 70) check = record_legacy();
    else if (t < 85) check = words_crc() ^ (16'h1 << $urandom_range(15));
    else             check = 16'($urandom);
  endtask

  task automatic test_directed_records();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rec_words.delete();
    send_record(16'h0000);
    drain_block();
    load_config(16'hA55A, 4'd1);
    rec_words = {16'h0000, 16'hA55A, 16'hFFFF};
    send_record(words_crc());
    send_record(record_legacy());
    rec_words = {16'h1234, 16'hA55A};
    send_record(words_crc() ^ 16'h0001);
    rec_words = {16'h0001, 16'hFFFF};
    send_record(words_crc());
    rec_words = {16'h8000, 16'h5AA5};
    send_record(words_crc());
    // record ends before the magic position
    rec_words = {16'hFFFF};
    send_record(words_crc());
  endtask

  task automatic test_erased_beats_magic();
    drain_block();
    load_config(16'hFFFF, 4'd0);
    rec_words = {16'hFFFF, 16'h0000};
    send_record(words_crc());
  endtask

  task automatic test_random_traffic(int idle, int stall, logic [15:0] magic, logic [3:0] pos,
                                     int n_items);
    int sent;
    logic [15:0] check;
    drain_block();
    load_config(magic, pos);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      build_random_record(check);
      send_record(check);
      sent += rec_words.size() + 1;
    end
  endtask

  task automatic test_backpressure();
    drain_block();
    load_config(16'($urandom), 4'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 400;
    for (int r = 0; r < 25; r++) begin
      rec_words.delete();
      repeat ($urandom_range(2, 1)) rec_words.push_back(random_data_word());
      rec_words[0] = magic_val_q;
      send_record(words_crc());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_records();
    test_erased_beats_magic();
    test_random_traffic(0, 0, 16'($urandom), 4'd0, 220);
    test_random_traffic(85, 0, 16'h0000, 4'd15, 220);
    test_random_traffic(0, 85, 16'($urandom), 4'($urandom), 220);
    test_random_traffic(11, 11, 16'($urandom), 4'($urandom_range(10, 4)), 220);
    test_backpressure();
    drain_block();
    if (mismatch_count == 0) begin
      $display("tb_log_record_checker: PASS");
    end else begin
      $display("tb_log_record_checker: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lrc_pkg.sv
design/log_record_checker.sv
design/lrc_checker.sv
verif/tb_log_record_checker.sv
